[rtl/owtr_pkg.sv]
// owtr_pkg: shared types, constants and the reading conversion of the
// one-wire temperature reader; no dependencies
`timescale 1ns / 1ps

package owtr_pkg;

    // field widths
    localparam int TICK_W  = 20;
    localparam int SHORT_W = 16;
    localparam int WORD_W  = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 20;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_DLY  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POST_PRESENCE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WRITE_SLOT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_READ_SAMPLE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_READ_RECOVER  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CONVERT_WAIT  = 3'd6;

    // register reset values
    localparam logic [SHORT_W-1:0] RST_RESET_LOW     = 16'd550;
    localparam logic [SHORT_W-1:0] RST_PRESENCE_DLY  = 16'd40;
    localparam logic [SHORT_W-1:0] RST_POST_PRESENCE = 16'd200;
    localparam logic [SHORT_W-1:0] RST_WRITE_SLOT    = 16'd40;
    localparam logic [SHORT_W-1:0] RST_READ_SAMPLE   = 16'd6;
    localparam logic [SHORT_W-1:0] RST_READ_RECOVER  = 16'd50;
    localparam logic [TICK_W-1:0]  RST_CONVERT_WAIT  = 20'd500;

    // bus commands
    localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
    localparam logic [7:0] CMD_CONVERT  = 8'h44;
    localparam logic [7:0] CMD_READ_PAD = 8'hBE;

    // fixed slot timings
    localparam logic [TICK_W-1:0] WR_REC_TICKS = 20'd3;
    localparam logic [TICK_W-1:0] LOW_TICKS    = 20'd1;

    // valid reading window and invalid marker
    localparam logic [11:0]       RAW_MAX       = 12'd640;
    localparam logic [WORD_W-1:0] TEMP_INVALID  = 16'hFFFF;

    // timing registers
    typedef struct packed {
        logic [SHORT_W-1:0] reset_low;
        logic [SHORT_W-1:0] presence_dly;
        logic [SHORT_W-1:0] post_presence;
        logic [SHORT_W-1:0] write_slot;
        logic [SHORT_W-1:0] read_sample;
        logic [SHORT_W-1:0] read_recover;
        logic [TICK_W-1:0]  convert_wait;
    } t_cfg;

    // raw word to hundredths of a degree, floor(raw12 * 25 / 4)
    function automatic logic [WORD_W-1:0] convert_raw(input logic [WORD_W-1:0] raw);
        logic [11:0] r12;
        logic [13:0] prod;
        r12  = raw[11:0];
        prod = 14'(r12) * 14'd25;
        if (r12 != 12'd0 && r12 < RAW_MAX) begin
            return WORD_W'(prod[13:2]);
        end
        return TEMP_INVALID;
    endfunction

endpackage

[rtl/owtr_in_if.sv]
// owtr_in_if: input channel of the reader, valid/ready plus request fields
// no dependencies
`timescale 1ns / 1ps

interface owtr_in_if;
    logic valid;
    logic ready;
    logic func;
    logic line_in;

    modport source (output valid, output func, output line_in, input ready);
    modport sink   (input valid, input func, input line_in, output ready);
endinterface

[rtl/owtr_out_if.sv]
// owtr_out_if: result channel of the reader, valid/ready plus status fields
// depends on owtr_pkg for widths
`timescale 1ns / 1ps

interface owtr_out_if;
    logic                       valid;
    logic                       ready;
    logic                       line_drive_low;
    logic                       busy_res;
    logic                       done_res;
    logic [owtr_pkg::WORD_W-1:0] temp_centi;
    logic [owtr_pkg::WORD_W-1:0] raw_reading;

    modport source (output valid, output line_drive_low, output busy_res,
                    output done_res, output temp_centi, output raw_reading,
                    input ready);
    modport sink   (input valid, input line_drive_low, input busy_res,
                    input done_res, input temp_centi, input raw_reading,
                    output ready);
endinterface

[rtl/onewire_temp_sensor_reader.sv]
// onewire_temp_sensor_reader: one-wire master that reads one temperature sample
// depends on owtr_pkg, owtr_in_if, owtr_out_if
`timescale 1ns / 1ps

// Usage
// i_in carries one word per microsecond tick (func = 0) with the sampled bus
// level, or a start request (func = 1) that begins a reading when idle.
// o_out returns exactly one word per accepted input word: the bus drive, busy,
// done and the last converted and raw readings, as they stand after that word.
// i_cfg_we / i_cfg_idx / i_cfg_data write the timing registers between words;
// a phase already running ends once its count reaches or passes the new value.
// A word accepted at a clock edge shows on o_out right after it. One word is
// taken per cycle, stalls aside; the sequencer state update and the result
// are one pass of logic from the state registers into the output register.
// The output register frees the input side: a new word is taken whenever the
// output is empty or being taken in the same cycle. When the receiver stalls
// the result holds and i_in.ready drops until it is taken.
// Reset puts the sequencer in idle, clears the readings, loads the timing
// registers with their default values and empties the output register.
// A missing presence pulse leaves the sequencer polling until the next reset.
module onewire_temp_sensor_reader (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    owtr_in_if.sink                             i_in,
    owtr_out_if.source                          o_out,
    input  logic                                i_cfg_we,
    input  logic [owtr_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [owtr_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    // sequencer phases
    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_RST_LOW  = 4'd1;
    localparam logic [3:0] PH_RST_REL  = 4'd2;
    localparam logic [3:0] PH_RST_POLL = 4'd3;
    localparam logic [3:0] PH_RST_POST = 4'd4;
    localparam logic [3:0] PH_WR_LOW   = 4'd5;
    localparam logic [3:0] PH_WR_DATA  = 4'd6;
    localparam logic [3:0] PH_WR_REC   = 4'd7;
    localparam logic [3:0] PH_CONV     = 4'd8;
    localparam logic [3:0] PH_RD_LOW   = 4'd9;
    localparam logic [3:0] PH_RD_REL   = 4'd10;
    localparam logic [3:0] PH_RD_REC   = 4'd11;

    // sequence steps
    localparam logic [2:0] ST_RESET1   = 3'd0;
    localparam logic [2:0] ST_SKIP1    = 3'd1;
    localparam logic [2:0] ST_CONVERT  = 3'd2;
    localparam logic [2:0] ST_RESET2   = 3'd3;
    localparam logic [2:0] ST_SKIP2    = 3'd4;
    localparam logic [2:0] ST_READ_CMD = 3'd5;
    localparam logic [2:0] ST_READ_LO  = 3'd6;
    localparam logic [2:0] ST_READ_HI  = 3'd7;

    localparam int TW = owtr_pkg::TICK_W;
    localparam int WW = owtr_pkg::WORD_W;

    owtr_pkg::t_cfg     r_cfg;
    logic [3:0]         r_phase,  n_phase;
    logic [TW-1:0]      r_tick,   n_tick;
    logic [2:0]         r_bit,    n_bit;
    logic [2:0]         r_step,   n_step;
    logic [7:0]         r_shift,  n_shift;
    logic [WW-1:0]      r_raw,    n_raw;
    logic [WW-1:0]      r_temp,   n_temp;
    logic               n_done;
    logic               n_drive;

    logic               r_ovalid;
    logic               r_odrive;
    logic               r_obusy;
    logic               r_odone;
    logic [WW-1:0]      r_otemp;
    logic [WW-1:0]      r_oraw;

    logic               accept;
    logic [TW-1:0]      tick_inc;
    logic [TW-1:0]      limit;
    logic               expired;
    logic               do_begin;
    logic [2:0]         begin_idx;
    logic               do_end;

    // handshake: take a word when the output register is free or draining
    assign i_in.ready = !r_ovalid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_low     <= owtr_pkg::RST_RESET_LOW;
            r_cfg.presence_dly  <= owtr_pkg::RST_PRESENCE_DLY;
            r_cfg.post_presence <= owtr_pkg::RST_POST_PRESENCE;
            r_cfg.write_slot    <= owtr_pkg::RST_WRITE_SLOT;
            r_cfg.read_sample   <= owtr_pkg::RST_READ_SAMPLE;
            r_cfg.read_recover  <= owtr_pkg::RST_READ_RECOVER;
            r_cfg.convert_wait  <= owtr_pkg::RST_CONVERT_WAIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                owtr_pkg::REG_RESET_LOW:     r_cfg.reset_low     <= i_cfg_data[15:0];
                owtr_pkg::REG_PRESENCE_DLY:  r_cfg.presence_dly  <= i_cfg_data[15:0];
                owtr_pkg::REG_POST_PRESENCE: r_cfg.post_presence <= i_cfg_data[15:0];
                owtr_pkg::REG_WRITE_SLOT:    r_cfg.write_slot    <= i_cfg_data[15:0];
                owtr_pkg::REG_READ_SAMPLE:   r_cfg.read_sample   <= i_cfg_data[15:0];
                owtr_pkg::REG_READ_RECOVER:  r_cfg.read_recover  <= i_cfg_data[15:0];
                owtr_pkg::REG_CONVERT_WAIT:  r_cfg.convert_wait  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // phase timer limit, one shared compare
    always_comb begin
        unique case (r_phase)
            PH_RST_LOW:  limit = TW'(r_cfg.reset_low);
            PH_RST_REL:  limit = TW'(r_cfg.presence_dly);
            PH_RST_POST: limit = TW'(r_cfg.post_presence);
            PH_WR_DATA:  limit = TW'(r_cfg.write_slot);
            PH_WR_REC:   limit = owtr_pkg::WR_REC_TICKS;
            PH_CONV:     limit = r_cfg.convert_wait;
            PH_RD_REL:   limit = TW'(r_cfg.read_sample);
            PH_RD_REC:   limit = TW'(r_cfg.read_recover);
            default:     limit = owtr_pkg::LOW_TICKS;
        endcase
    end

    assign tick_inc = r_tick + TW'(1);
    assign expired  = tick_inc >= limit;

    // sequencer next state
    always_comb begin
        n_phase   = r_phase;
        n_tick    = r_tick;
        n_bit     = r_bit;
        n_step    = r_step;
        n_shift   = r_shift;
        n_raw     = r_raw;
        n_temp    = r_temp;
        n_done    = 1'b0;
        do_begin  = 1'b0;
        begin_idx = ST_RESET1;
        do_end    = 1'b0;

        if (r_phase == PH_IDLE) begin
            if (i_in.func) begin
                do_begin = 1'b1;
            end
        end else if (!i_in.func) begin
            // timed phases count up and clear on expiry
            if (r_phase != PH_RST_POLL) begin
                n_tick = expired ? '0 : tick_inc;
            end
            unique case (r_phase)
                PH_RST_LOW:  if (expired) n_phase = PH_RST_REL;
                PH_RST_REL:  if (expired) n_phase = PH_RST_POLL;
                PH_RST_POLL: begin
                    if (!i_in.line_in) begin
                        n_phase = PH_RST_POST;
                        n_tick  = '0;
                    end
                end
                PH_RST_POST: if (expired) do_end = 1'b1;
                PH_WR_LOW:   if (expired) n_phase = PH_WR_DATA;
                PH_WR_DATA:  if (expired) n_phase = PH_WR_REC;
                PH_WR_REC, PH_RD_REC: begin
                    if (expired) begin
                        n_bit = r_bit + 3'd1;
                        if (n_bit == 3'd0) begin
                            do_end = 1'b1;
                        end else begin
                            n_phase = (r_phase == PH_WR_REC) ? PH_WR_LOW : PH_RD_LOW;
                        end
                    end
                end
                PH_CONV: begin
                    if (expired) begin
                        do_begin  = 1'b1;
                        begin_idx = ST_RESET2;
                    end
                end
                PH_RD_LOW:   if (expired) n_phase = PH_RD_REL;
                PH_RD_REL: begin
                    if (expired) begin
                        n_shift[r_bit] = i_in.line_in;
                        n_phase        = PH_RD_REC;
                    end
                end
                default:     n_phase = PH_IDLE;
            endcase
        end

        // end of a step
        if (do_end) begin
            unique case (r_step)
                ST_CONVERT: begin
                    n_phase = PH_CONV;
                    n_tick  = '0;
                end
                ST_READ_LO: begin
                    n_raw     = {r_raw[15:8], r_shift};
                    do_begin  = 1'b1;
                    begin_idx = ST_READ_HI;
                end
                ST_READ_HI: begin
                    n_raw   = {r_shift, r_raw[7:0]};
                    n_temp  = owtr_pkg::convert_raw({r_shift, r_raw[7:0]});
                    n_phase = PH_IDLE;
                    n_step  = ST_RESET1;
                    n_bit   = 3'd0;
                    n_tick  = '0;
                    n_done  = 1'b1;
                end
                default: begin
                    do_begin  = 1'b1;
                    begin_idx = r_step + 3'd1;
                end
            endcase
        end

        // start of a step
        if (do_begin) begin
            n_step = begin_idx;
            n_tick = '0;
            n_bit  = 3'd0;
            unique case (begin_idx)
                ST_RESET1, ST_RESET2: n_phase = PH_RST_LOW;
                ST_SKIP1, ST_SKIP2: begin
                    n_shift = owtr_pkg::CMD_SKIP_ROM;
                    n_phase = PH_WR_LOW;
                end
                ST_CONVERT: begin
                    n_shift = owtr_pkg::CMD_CONVERT;
                    n_phase = PH_WR_LOW;
                end
                ST_READ_CMD: begin
                    n_shift = owtr_pkg::CMD_READ_PAD;
                    n_phase = PH_WR_LOW;
                end
                default: begin
                    n_shift = 8'h00;
                    n_phase = PH_RD_LOW;
                end
            endcase
        end
    end

    // bus drive for the phase after this word
    always_comb begin
        unique case (n_phase)
            PH_RST_LOW, PH_WR_LOW, PH_RD_LOW: n_drive = 1'b1;
            PH_WR_DATA:                       n_drive = ~n_shift[n_bit];
            default:                          n_drive = 1'b0;
        endcase
    end

    // sequencer state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_tick  <= '0;
            r_bit   <= 3'd0;
            r_step  <= ST_RESET1;
            r_shift <= 8'h00;
            r_raw   <= '0;
            r_temp  <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_bit   <= n_bit;
            r_step  <= n_step;
            r_shift <= n_shift;
            r_raw   <= n_raw;
            r_temp  <= n_temp;
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (accept) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_odrive <= n_drive;
            r_obusy  <= (n_phase != PH_IDLE);
            r_odone  <= n_done;
            r_otemp  <= n_temp;
            r_oraw   <= n_raw;
        end
    end

    assign o_out.valid          = r_ovalid;
    assign o_out.line_drive_low = r_odrive;
    assign o_out.busy_res       = r_obusy;
    assign o_out.done_res       = r_odone;
    assign o_out.temp_centi     = r_otemp;
    assign o_out.raw_reading    = r_oraw;

    // a tick while idle leaves the sequencer idle
    a_idle_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && r_phase == PH_IDLE && !i_in.func |=> r_phase == PH_IDLE)
        else $error("tick while idle moved the sequencer");

    // a completed reading returns to idle and shows a result
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && n_done |=> r_phase == PH_IDLE && r_ovalid && r_odone && !r_obusy)
        else $error("completed reading not reported as idle");

    // the bus is never pulled low while no sequence runs
    a_idle_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !r_obusy |-> !r_odrive)
        else $error("bus driven low while idle");

    // a stalled result blocks new words
    a_stall_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !o_out.ready |-> !i_in.ready)
        else $error("word taken while result stalled");

endmodule

[bench/onewire_temp_sensor_reader_test.sv]
// onewire_temp_sensor_reader_test: self-checking bench for the one-wire temperature reader
// depends on owtr_pkg, owtr_in_if, owtr_out_if and onewire_temp_sensor_reader
// a word-level predictor plus a sensor stand-in drive table-led and random readings
`timescale 1ns / 1ps

module onewire_temp_sensor_reader_test;

    localparam int TICK_W     = owtr_pkg::TICK_W;
    localparam int WORD_W     = owtr_pkg::WORD_W;
    localparam int SHORT_W    = owtr_pkg::SHORT_W;
    localparam int CFG_IDX_W  = owtr_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = owtr_pkg::CFG_DATA_W;

    localparam int unsigned RAND_WORDS     = 300;
    localparam int unsigned SETTLE_CYCLES  = 4;
    localparam int unsigned WATCHDOG_LIMIT = 1000;

    localparam logic FN_TICK  = 1'b0;
    localparam logic FN_START = 1'b1;

    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    // sequencer phases as the predictor tracks them
    typedef enum logic [4:0] {
        SEQ_IDLE, SEQ_RST_LOW, SEQ_RST_REL, SEQ_RST_POLL, SEQ_RST_POST,
        SEQ_WR_LOW, SEQ_WR_DATA, SEQ_WR_REC, SEQ_CONV,
        SEQ_RD_LOW, SEQ_RD_REL, SEQ_RD_REC
    } t_seq_phase;

    // steps of one reading
    typedef enum logic [2:0] {
        STEP_RESET1, STEP_SKIP1, STEP_CONVERT, STEP_RESET2,
        STEP_SKIP2, STEP_READ_CMD, STEP_READ_LO, STEP_READ_HI
    } t_step;

    typedef struct packed {
        logic              drive;
        logic              busy;
        logic              done;
        logic [WORD_W-1:0] temp;
        logic [WORD_W-1:0] raw;
    } t_bus_status;

    localparam t_bus_status ST_IDLE      = '0;
    localparam t_bus_status ST_RESET_LOW = '{1'b1, 1'b1, 1'b0, 16'h0, 16'h0};
    localparam t_bus_status ST_RELEASED  = '{1'b0, 1'b1, 1'b0, 16'h0, 16'h0};

    // rows of the directed table
    typedef enum logic [1:0] {ROW_WORD, ROW_RUN, ROW_CFG_MIN} t_row_op;
    typedef enum logic {LN_LOW, LN_HIGH} t_line_src;

    typedef struct {
        t_row_op     op;
        logic        func;
        t_line_src   src;
        int unsigned reps;
        logic [15:0] word;
        bit          typed;
        t_bus_status want;
    } t_stim_row;

    logic clk;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    owtr_in_if  in_ch();
    owtr_out_if out_ch();

    onewire_temp_sensor_reader uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // predictor state and register copy
    t_seq_phase        pred_phase;
    logic [TICK_W-1:0] pred_ticks;
    logic [2:0]        pred_bit;
    t_step             pred_step;
    logic [7:0]        pred_shift;
    logic [WORD_W-1:0] pred_raw;
    logic [WORD_W-1:0] pred_temp;
    owtr_pkg::t_cfg    pred_cfg;

    t_bus_status status_q[$];
    t_stim_row   dir_rows[$];

    int unsigned n_errors;
    int unsigned n_words;
    int unsigned n_readings;
    int unsigned n_valid_temps;
    int unsigned n_reg_writes;
    int unsigned idle_cycles;
    int unsigned stall_left;
    int unsigned src_idle_pct;
    int unsigned snk_stall_pct;
    bit          quiet;

    // clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // ---------------- predictor ----------------

    // count one tick of a timed phase, true on its last tick
    function automatic bit slot_elapsed(input logic [TICK_W-1:0] limit);
        pred_ticks = pred_ticks + 1'b1;
        if (pred_ticks >= limit) begin
            pred_ticks = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void start_step(input t_step s);
        pred_step  = s;
        pred_ticks = '0;
        pred_bit   = '0;
        case (s)
            STEP_RESET1, STEP_RESET2: pred_phase = SEQ_RST_LOW;
            STEP_SKIP1, STEP_SKIP2: begin
                pred_shift = owtr_pkg::CMD_SKIP_ROM;
                pred_phase = SEQ_WR_LOW;
            end
            STEP_CONVERT: begin
                pred_shift = owtr_pkg::CMD_CONVERT;
                pred_phase = SEQ_WR_LOW;
            end
            STEP_READ_CMD: begin
                pred_shift = owtr_pkg::CMD_READ_PAD;
                pred_phase = SEQ_WR_LOW;
            end
            default: begin
                pred_shift = '0;
                pred_phase = SEQ_RD_LOW;
            end
        endcase
    endfunction

    // hundredths of a degree from the 12-bit reading, invalid outside the window
    function automatic logic [WORD_W-1:0] to_centi(input logic [WORD_W-1:0] w);
        int unsigned r12;
        r12 = w[11:0];
        if (r12 == 0 || r12 >= owtr_pkg::RAW_MAX)
            return owtr_pkg::TEMP_INVALID;
        return WORD_W'((r12 * 25) / 4);
    endfunction

    // close the current step, true when the whole reading is complete
    function automatic bit finish_step();
        case (pred_step)
            STEP_CONVERT: begin
                pred_phase = SEQ_CONV;
                pred_ticks = '0;
                return 1'b0;
            end
            STEP_READ_LO: begin
                pred_raw[7:0] = pred_shift;
                start_step(STEP_READ_HI);
                return 1'b0;
            end
            STEP_READ_HI: begin
                pred_raw[15:8] = pred_shift;
                pred_temp  = to_centi(pred_raw);
                pred_phase = SEQ_IDLE;
                pred_step  = STEP_RESET1;
                pred_bit   = '0;
                pred_ticks = '0;
                return 1'b1;
            end
            default: begin
                start_step(t_step'(pred_step + 3'd1));
                return 1'b0;
            end
        endcase
    endfunction

    // advance the predictor by one word and return the status it shows after it
    function automatic t_bus_status predict_word(input logic f, input logic l);
        t_bus_status r;
        bit          fin;
        fin = 1'b0;
        if (pred_phase == SEQ_IDLE) begin
            if (f == FN_START)
                start_step(STEP_RESET1);
        end else if (f == FN_TICK) begin
            case (pred_phase)
                SEQ_RST_LOW:
                    if (slot_elapsed(TICK_W'(pred_cfg.reset_low))) pred_phase = SEQ_RST_REL;
                SEQ_RST_REL:
                    if (slot_elapsed(TICK_W'(pred_cfg.presence_dly))) pred_phase = SEQ_RST_POLL;
                SEQ_RST_POLL:
                    if (!l) begin
                        pred_phase = SEQ_RST_POST;
                        pred_ticks = '0;
                    end
                SEQ_RST_POST:
                    if (slot_elapsed(TICK_W'(pred_cfg.post_presence))) fin = finish_step();
                SEQ_WR_LOW:
                    if (slot_elapsed(owtr_pkg::LOW_TICKS)) pred_phase = SEQ_WR_DATA;
                SEQ_WR_DATA:
                    if (slot_elapsed(TICK_W'(pred_cfg.write_slot))) pred_phase = SEQ_WR_REC;
                SEQ_WR_REC:
                    if (slot_elapsed(owtr_pkg::WR_REC_TICKS)) begin
                        pred_bit = pred_bit + 3'd1;
                        if (pred_bit == 3'd0) fin = finish_step();
                        else pred_phase = SEQ_WR_LOW;
                    end
                SEQ_CONV:
                    if (slot_elapsed(pred_cfg.convert_wait)) start_step(STEP_RESET2);
                SEQ_RD_LOW:
                    if (slot_elapsed(owtr_pkg::LOW_TICKS)) pred_phase = SEQ_RD_REL;
                SEQ_RD_REL:
                    if (slot_elapsed(TICK_W'(pred_cfg.read_sample))) begin
                        pred_shift[pred_bit] = l;
                        pred_phase = SEQ_RD_REC;
                    end
                SEQ_RD_REC:
                    if (slot_elapsed(TICK_W'(pred_cfg.read_recover))) begin
                        pred_bit = pred_bit + 3'd1;
                        if (pred_bit == 3'd0) fin = finish_step();
                        else pred_phase = SEQ_RD_LOW;
                    end
                default: pred_phase = SEQ_IDLE;
            endcase
        end

        // bus drive as it stands after the word
        case (pred_phase)
            SEQ_RST_LOW, SEQ_WR_LOW, SEQ_RD_LOW: r.drive = 1'b1;
            SEQ_WR_DATA: r.drive = ~pred_shift[pred_bit];
            default: r.drive = 1'b0;
        endcase
        r.busy = (pred_phase != SEQ_IDLE);
        r.done = fin;
        r.temp = pred_temp;
        r.raw  = pred_raw;
        if (fin) begin
            n_readings++;
            if (pred_temp != owtr_pkg::TEMP_INVALID) n_valid_temps++;
        end
        return r;
    endfunction

    // register write as the block sees it, upper data bits dropped for short registers
    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] d);
        case (idx)
            owtr_pkg::REG_RESET_LOW:     pred_cfg.reset_low     = d[SHORT_W-1:0];
            owtr_pkg::REG_PRESENCE_DLY:  pred_cfg.presence_dly  = d[SHORT_W-1:0];
            owtr_pkg::REG_POST_PRESENCE: pred_cfg.post_presence = d[SHORT_W-1:0];
            owtr_pkg::REG_WRITE_SLOT:    pred_cfg.write_slot    = d[SHORT_W-1:0];
            owtr_pkg::REG_READ_SAMPLE:   pred_cfg.read_sample   = d[SHORT_W-1:0];
            owtr_pkg::REG_READ_RECOVER:  pred_cfg.read_recover  = d[SHORT_W-1:0];
            owtr_pkg::REG_CONVERT_WAIT:  pred_cfg.convert_wait  = d;
            default: ;
        endcase
    endfunction

    // ---------------- stimulus helpers ----------------

    // bus level a well-behaved sensor would show for the next tick
    function automatic logic sensor_line(input logic [15:0] word, input int unsigned low_pct);
        case (pred_phase)
            SEQ_RST_POLL: return ($urandom_range(0, 99) < low_pct) ? 1'b0 : 1'b1;
            SEQ_RD_REL:
                if (pred_step == STEP_READ_LO) return word[{1'b0, pred_bit}];
                else return word[{1'b1, pred_bit}];
            default: return 1'(($urandom_range(0, 1)));
        endcase
    endfunction

    // reading values: window edges, in-window values with random sign bits, anything
    function automatic logic [15:0] pick_raw();
        case ($urandom_range(0, 7))
            0: case ($urandom_range(0, 5))
                   0: return 16'h0000;
                   1: return 16'h0001;
                   2: return 16'h027F;
                   3: return 16'h0280;
                   4: return 16'hFFFF;
                   default: return 16'hF000;
               endcase
            1, 2, 3, 4: return {4'($urandom), 12'($urandom_range(1, 639))};
            default: return 16'($urandom);
        endcase
    endfunction

    // mostly the shortest timings so that many readings fit in the run
    function automatic logic [15:0] rand_ticks();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6: return 16'($urandom_range(0, 2));
            7, 8: return 16'($urandom_range(3, 12));
            default: return 16'($urandom_range(13, 40));
        endcase
    endfunction

    function automatic owtr_pkg::t_cfg rand_cfg();
        owtr_pkg::t_cfg c;
        c.reset_low     = rand_ticks();
        c.presence_dly  = rand_ticks();
        c.post_presence = rand_ticks();
        c.write_slot    = rand_ticks();
        c.read_sample   = rand_ticks();
        c.read_recover  = rand_ticks();
        c.convert_wait  = TICK_W'(rand_ticks());
        return c;
    endfunction

    function automatic t_stim_row mk_row(input t_row_op op, input logic f,
                                         input t_line_src src, input int unsigned reps,
                                         input logic [15:0] w, input bit typed,
                                         input t_bus_status want);
        t_stim_row r;
        r.op = op; r.func = f; r.src = src; r.reps = reps;
        r.word = w; r.typed = typed; r.want = want;
        return r;
    endfunction

    // drive one word, wait until it is taken, then queue what it should produce
    task automatic send_word(input logic f, input logic l, input bit typed,
                             input t_bus_status want);
        t_bus_status guess;
        if (!quiet && $urandom_range(0, 99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.func    <= f;
        in_ch.line_in <= l;
        do @(posedge clk); while (!in_ch.ready);
        guess = predict_word(f, l);
        status_q.push_back(typed ? want : guess);
        n_words++;
        @(negedge clk);
    endtask

    // tick until the running reading completes
    task automatic finish_reading(input logic [15:0] word, input int unsigned low_pct,
                                  input bit noisy);
        while (pred_phase != SEQ_IDLE) begin
            if (noisy && $urandom_range(0, 39) == 0)
                send_word(FN_START, 1'($urandom), 1'b0, ST_IDLE);
            else if (noisy && pred_phase == SEQ_RD_REL && $urandom_range(0, 15) == 0)
                send_word(FN_TICK, 1'($urandom), 1'b0, ST_IDLE);
            else
                send_word(FN_TICK, sensor_line(word, low_pct), 1'b0, ST_IDLE);
        end
    endtask

    task automatic run_reading(input logic [15:0] word, input bit noisy);
        send_word(FN_START, 1'($urandom), 1'b0, ST_IDLE);
        finish_reading(word, noisy ? 25 : 100, noisy);
    endtask

    // let every queued result come back, then let the bench settle
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (status_q.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= d;
        @(posedge clk);
        apply_reg(idx, d);
        n_reg_writes++;
        @(negedge clk);
    endtask

    // write every register, junk in the unused upper bits of the short ones
    task automatic load_config(input owtr_pkg::t_cfg c);
        put_reg(owtr_pkg::REG_RESET_LOW,     {4'($urandom), c.reset_low});
        put_reg(owtr_pkg::REG_PRESENCE_DLY,  {4'($urandom), c.presence_dly});
        put_reg(owtr_pkg::REG_POST_PRESENCE, {4'($urandom), c.post_presence});
        put_reg(owtr_pkg::REG_WRITE_SLOT,    {4'($urandom), c.write_slot});
        put_reg(owtr_pkg::REG_READ_SAMPLE,   {4'($urandom), c.read_sample});
        put_reg(owtr_pkg::REG_READ_RECOVER,  {4'($urandom), c.read_recover});
        put_reg(owtr_pkg::REG_CONVERT_WAIT,  c.convert_wait);
        if ($urandom_range(0, 1)) put_reg(REG_UNUSED, CFG_DATA_W'($urandom));
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // ---------------- result check ----------------

    function automatic void check_field(input string name, input logic [15:0] want_v,
                                        input logic [15:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want_v, got_v);
            n_errors++;
        end
    endfunction

    always @(posedge clk) begin : result_check
        t_bus_status want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (status_q.size() == 0) begin
                $display("%0t: result word, expected none, got drive=%b busy=%b done=%b",
                         $time, out_ch.line_drive_low, out_ch.busy_res, out_ch.done_res);
                $display("%0t: unexpected word carried temp=%h raw=%h",
                         $time, out_ch.temp_centi, out_ch.raw_reading);
                n_errors++;
            end else begin
                want = status_q.pop_front();
                check_field("line_drive_low", 16'(want.drive), 16'(out_ch.line_drive_low));
                check_field("busy_res", 16'(want.busy), 16'(out_ch.busy_res));
                check_field("done_res", 16'(want.done), 16'(out_ch.done_res));
                check_field("temp_centi", want.temp, out_ch.temp_centi);
                check_field("raw_reading", want.raw, out_ch.raw_reading);
            end
        end
    end

    // receiver stalls in bursts of random length
    always @(negedge clk) begin
        if (stall_left != 0) begin
            stall_left   <= stall_left - 1;
            out_ch.ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 99) < snk_stall_pct) begin
            stall_left   <= $urandom_range(0, 12);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // watchdog on cycles where no word moves on either side
    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, status_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ---------------- main sequence ----------------

    initial begin
        int unsigned rand_base;

        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_idx       = '0;
        cfg_data      = '0;
        in_ch.valid   = 1'b0;
        in_ch.func    = FN_TICK;
        in_ch.line_in = 1'b1;
        out_ch.ready  = 1'b0;
        n_errors      = 0;
        n_words       = 0;
        n_readings    = 0;
        n_valid_temps = 0;
        n_reg_writes  = 0;
        idle_cycles   = 0;
        stall_left    = 0;
        src_idle_pct  = 10;
        snk_stall_pct = 10;
        quiet         = 1'b0;

        // predictor after reset
        pred_phase = SEQ_IDLE;
        pred_ticks = '0;
        pred_bit   = '0;
        pred_step  = STEP_RESET1;
        pred_shift = '0;
        pred_raw   = '0;
        pred_temp  = '0;
        pred_cfg   = '{owtr_pkg::RST_RESET_LOW, owtr_pkg::RST_PRESENCE_DLY,
                       owtr_pkg::RST_POST_PRESENCE, owtr_pkg::RST_WRITE_SLOT,
                       owtr_pkg::RST_READ_SAMPLE, owtr_pkg::RST_READ_RECOVER,
                       owtr_pkg::RST_CONVERT_WAIT};

        // directed table, default reset pulse first, then the shortest timings
        dir_rows.push_back(mk_row(ROW_WORD, FN_TICK,  LN_HIGH, 1, 16'h0, 1'b1, ST_IDLE));
        dir_rows.push_back(mk_row(ROW_WORD, FN_TICK,  LN_LOW,  1, 16'h0, 1'b1, ST_IDLE));
        dir_rows.push_back(mk_row(ROW_WORD, FN_START, LN_HIGH, 1, 16'h0, 1'b1, ST_RESET_LOW));
        dir_rows.push_back(mk_row(ROW_WORD, FN_START, LN_LOW,  1, 16'h0, 1'b1, ST_RESET_LOW));
        dir_rows.push_back(mk_row(ROW_WORD, FN_TICK,  LN_HIGH, 549, 16'h0, 1'b0, ST_IDLE));
        dir_rows.push_back(mk_row(ROW_WORD, FN_TICK,  LN_LOW,  1, 16'h0, 1'b1, ST_RELEASED));
        // shorten the running sequence and finish it
        dir_rows.push_back(mk_row(ROW_CFG_MIN, FN_TICK, LN_LOW, 0, 16'h0, 1'b0, ST_IDLE));
        dir_rows.push_back(mk_row(ROW_RUN,  FN_TICK,  LN_LOW,  0, 16'h0191, 1'b0, ST_IDLE));
        // missing presence pulse holds the poll, a start meanwhile is ignored
        dir_rows.push_back(mk_row(ROW_WORD, FN_START, LN_HIGH, 1, 16'h0, 1'b0, ST_IDLE));
        dir_rows.push_back(mk_row(ROW_WORD, FN_TICK,  LN_HIGH, 30, 16'h0, 1'b0, ST_IDLE));
        dir_rows.push_back(mk_row(ROW_WORD, FN_START, LN_HIGH, 1, 16'h0, 1'b0, ST_IDLE));
        dir_rows.push_back(mk_row(ROW_RUN,  FN_TICK,  LN_LOW,  0, 16'h0000, 1'b0, ST_IDLE));
        // window edges and all ones
        dir_rows.push_back(mk_row(ROW_WORD, FN_START, LN_LOW,  1, 16'h0, 1'b0, ST_IDLE));
        dir_rows.push_back(mk_row(ROW_RUN,  FN_TICK,  LN_LOW,  0, 16'h0001, 1'b0, ST_IDLE));
        dir_rows.push_back(mk_row(ROW_WORD, FN_START, LN_HIGH, 1, 16'h0, 1'b0, ST_IDLE));
        dir_rows.push_back(mk_row(ROW_RUN,  FN_TICK,  LN_LOW,  0, 16'h027F, 1'b0, ST_IDLE));
        dir_rows.push_back(mk_row(ROW_WORD, FN_START, LN_LOW,  1, 16'h0, 1'b0, ST_IDLE));
        dir_rows.push_back(mk_row(ROW_RUN,  FN_TICK,  LN_LOW,  0, 16'h0280, 1'b0, ST_IDLE));
        dir_rows.push_back(mk_row(ROW_WORD, FN_START, LN_HIGH, 1, 16'h0, 1'b0, ST_IDLE));
        dir_rows.push_back(mk_row(ROW_RUN,  FN_TICK,  LN_LOW,  0, 16'hFFFF, 1'b0, ST_IDLE));

        // synchronous reset, then release it
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // walk the directed table
        foreach (dir_rows[i]) begin
            case (dir_rows[i].op)
                ROW_WORD:
                    repeat (dir_rows[i].reps)
                        send_word(dir_rows[i].func, dir_rows[i].src == LN_HIGH,
                                  dir_rows[i].typed, dir_rows[i].want);
                ROW_RUN: finish_reading(dir_rows[i].word, 100, 1'b0);
                default: begin
                    drain();
                    load_config('0);
                end
            endcase
        end

        // random phases: fresh timings, a reading each, noise in between
        rand_base = n_words;
        while (n_words - rand_base < RAND_WORDS) begin
            drain();
            load_config(rand_cfg());
            case ($urandom_range(0, 3))
                0: src_idle_pct = 0;
                1: src_idle_pct = 3;
                2: src_idle_pct = 10;
                default: src_idle_pct = 30;
            endcase
            case ($urandom_range(0, 3))
                0: snk_stall_pct = 0;
                1: snk_stall_pct = 3;
                2: snk_stall_pct = 10;
                default: snk_stall_pct = 30;
            endcase
            repeat ($urandom_range(0, 3)) send_word(FN_TICK, 1'($urandom), 1'b0, ST_IDLE);
            run_reading(pick_raw(), $urandom_range(0, 3) != 0);
        end

        // last part: one reading with no idling on either side
        drain();
        quiet = 1'b1;
        load_config('0);
        run_reading(pick_raw(), 1'b0);

        drain();
        $display("run covered %0d input words and %0d register writes", n_words, n_reg_writes);
        $display("%0d readings completed, %0d inside the valid window, %0d mismatches",
                 n_readings, n_valid_temps, n_errors);
        if (n_errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
